// ===== sv/prd_pkg.sv =====
// Shared constants, types and field decode for the position report deframer.
`default_nettype none

package prd_pkg;

	localparam int unsigned FRAME_LEN   = 30;
	localparam int unsigned LAST_IDX    = FRAME_LEN - 1;
	// bytes 2 .. FRAME_LEN-2 are held; the final byte is checked as it arrives
	localparam int unsigned SHIFT_DEPTH = FRAME_LEN - 3;
	localparam int unsigned IDX_W       = $clog2(SHIFT_DEPTH);
	localparam int unsigned CNT_W       = 7;

	localparam logic [7:0] MARK_HEAD = 8'hFA;
	localparam logic [7:0] MARK_TAIL = 8'hBB;

	typedef logic [7:0]                    byte_t;
	typedef logic [CNT_W-1:0]              cnt_t;
	typedef logic [SHIFT_DEPTH-1:0][7:0]   shift_t;

	typedef struct packed {
		logic at_last;     // next collected byte closes the frame
		logic frame_done;  // closing byte taken this cycle
		logic tail_good;   // both tail bytes match
	} hunt_stat_t;

	typedef struct packed {
		logic signed [15:0] tag_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] var_x;
		logic signed [15:0] var_y;
		logic signed [15:0] var_z;
		logic signed [15:0] cov_xy;
		logic signed [15:0] cov_xz;
		logic signed [15:0] cov_yz;
	} result_t;

	// newest byte sits at tap 0, so frame byte k is at tap FRAME_LEN-2-k
	function automatic byte_t frame_byte(shift_t s, int unsigned k);
		return s[IDX_W'(FRAME_LEN - 2 - k)];
	endfunction

	function automatic logic [15:0] get16(shift_t s, int unsigned k);
		return {frame_byte(s, k + 1), frame_byte(s, k)};
	endfunction

	function automatic logic [31:0] get32(shift_t s, int unsigned k);
		return {get16(s, k + 2), get16(s, k)};
	endfunction

	function automatic result_t decode_frame(shift_t s);
		result_t r;
		r.tag_id = get16(s, 2);
		r.pos_x  = get32(s, 4);
		r.pos_y  = get32(s, 8);
		r.pos_z  = get32(s, 12);
		r.var_x  = get16(s, 16);
		r.var_y  = get16(s, 18);
		r.var_z  = get16(s, 20);
		r.cov_xy = get16(s, 22);
		r.cov_xz = get16(s, 24);
		r.cov_yz = get16(s, 26);
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/prd_hunt.sv =====
// Header hunt, byte counter and frame shift line.
`default_nettype none

module prd_hunt
	import prd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire byte_t      rx_byte,
	output hunt_stat_t      stat,
	output shift_t          shift
);

	logic   prev_mark_q;
	cnt_t   count_q;
	shift_t shift_q;
	logic   collecting;
	logic   at_last;

	assign collecting      = (count_q != '0);
	assign at_last         = (count_q == CNT_W'(LAST_IDX));
	assign stat.at_last    = at_last;
	assign stat.frame_done = accept && at_last;
	assign stat.tail_good  = (shift_q[0] == MARK_TAIL) && (rx_byte == MARK_TAIL);
	assign shift           = shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mark_q <= 1'b0;
			count_q     <= '0;
		end else if (accept) begin
			if (!collecting) begin
				if (rx_byte == MARK_HEAD) begin
					if (prev_mark_q) begin
						count_q     <= CNT_W'(2);
						prev_mark_q <= 1'b0;
					end else begin
						prev_mark_q <= 1'b1;
					end
				end else begin
					prev_mark_q <= 1'b0;
				end
			end else if (at_last) begin
				count_q     <= '0;
				prev_mark_q <= 1'b0;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	// payload shift line, only moves while gathering the frame body
	always_ff @(posedge clk) begin
		if (accept && collecting && !at_last) begin
			shift_q <= {shift_q[SHIFT_DEPTH-2:0], rx_byte};
		end
	end

endmodule

`default_nettype wire

// ===== sv/prd_outreg.sv =====
// Field decode and result output register.
`default_nettype none

module prd_outreg
	import prd_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   load,
	input  wire shift_t shift,
	input  wire logic   out_ready,
	output logic        out_valid,
	output result_t     result
);

	logic    valid_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= decode_frame(shift);
		end
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule

`default_nettype wire

// ===== sv/position_report_deframer_unit.sv =====
// Top level of the position report deframer: byte stream in, decoded reports out.
// A report is valid the cycle after the transaction carrying its last tail byte.
// Throughput: one byte per cycle; in_ready drops only when the closing byte of a frame
// arrives while the previous report still waits in the output register.
// Reset (arst_n, async, active low) clears the hunt state, counter and output valid.
`default_nettype none

module position_report_deframer_unit
	import prd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      tag_id,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      pos_z,
	output logic signed [15:0]      var_x,
	output logic signed [15:0]      var_y,
	output logic signed [15:0]      var_z,
	output logic signed [15:0]      cov_xy,
	output logic signed [15:0]      cov_xz,
	output logic signed [15:0]      cov_yz
);

	hunt_stat_t stat;
	shift_t     shift;
	result_t    result;
	logic       accept;
	logic       load;

	// Only the closing byte of a frame can produce a report, so only that byte
	// has to wait for the output register; every other byte flows freely.
	assign in_ready = !(stat.at_last && out_valid && !out_ready);
	assign accept   = in_valid && in_ready;

	// Report loads when the frame closes with a good tail; a bad tail just
	// drops the frame and the hunt restarts with the next byte.
	assign load = stat.frame_done && stat.tail_good;

	prd_hunt u_hunt (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.stat    (stat),
		.shift   (shift)
	);

	prd_outreg u_outreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.shift     (shift),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.result    (result)
	);

	assign tag_id = result.tag_id;
	assign pos_x  = result.pos_x;
	assign pos_y  = result.pos_y;
	assign pos_z  = result.pos_z;
	assign var_x  = result.var_x;
	assign var_y  = result.var_y;
	assign var_z  = result.var_z;
	assign cov_xy = result.cov_xy;
	assign cov_xz = result.cov_xz;
	assign cov_yz = result.cov_yz;

endmodule

`default_nettype wire

// ===== sv/prd_checker.sv =====
// Port-level assertions for the position report deframer, bound to the top level.
`default_nettype none

module prd_checker
	import prd_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [7:0]         rx_byte,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [15:0] tag_id,
	input wire logic signed [31:0] pos_x,
	input wire logic signed [31:0] pos_y,
	input wire logic signed [31:0] pos_z,
	input wire logic signed [15:0] var_x,
	input wire logic signed [15:0] var_y,
	input wire logic signed [15:0] var_z,
	input wire logic signed [15:0] cov_xy,
	input wire logic signed [15:0] cov_xz,
	input wire logic signed [15:0] cov_yz
);

	// a stalled report stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_id)
			&& $stable(pos_x) && $stable(pos_y) && $stable(pos_z)
			&& $stable(var_x) && $stable(var_y) && $stable(var_z)
			&& $stable(cov_xy) && $stable(cov_xz) && $stable(cov_yz))
		else $error("report dropped or changed while stalled");

	// a taken report with no byte transaction beside it leaves the output empty
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
		else $error("report followed by another without a byte transaction");

	// input backpressure only comes from a full, stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting report");

	// a new report follows a tail byte transaction
	a_report_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && rx_byte == MARK_TAIL))
		else $error("report raised without a tail byte transaction");

endmodule

bind position_report_deframer_unit prd_checker u_prd_checker (.*);

`default_nettype wire
